// ===== rtl/triggered_frame_deframer_assert.svh =====
// Assertion macros for the triggered frame deframer.
`ifndef TRIGGERED_FRAME_DEFRAMER_ASSERT_SVH
`define TRIGGERED_FRAME_DEFRAMER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define TFD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tfd check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define TFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tfd check failed");

`endif

// ===== rtl/tfd_pkg.sv =====
// Shared types and constants for the triggered frame deframer.
package tfd_pkg;

  localparam int NUM_CHANNELS_DEF = 21;
  localparam int FRAME_BYTES_DEF  = 46;

  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_TRIG = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_STAT = 2'd3;

  localparam logic [2:0] K_HEAD = 3'd0;
  localparam logic [2:0] K_CHAN = 3'd1;
  localparam logic [2:0] K_NONE = 3'd2;
  localparam logic [2:0] K_PEND = 3'd3;
  localparam logic [2:0] K_TOUT = 3'd4;
  localparam logic [2:0] K_TRIG = 3'd5;
  localparam logic [2:0] K_STAT = 3'd6;

  localparam logic [2:0] C_XOR    = 3'd0;
  localparam logic [2:0] C_GAP    = 3'd1;
  localparam logic [2:0] C_LATE   = 3'd2;
  localparam logic [2:0] C_OK     = 3'd3;
  localparam logic [2:0] C_MISS   = 3'd4;
  localparam logic [2:0] C_SENT   = 3'd5;
  localparam logic [2:0] C_RESYNC = 3'd6;
  localparam logic [2:0] C_MAXLAT = 3'd7;

  localparam logic [1:0] ANS_WAIT    = 2'd0;
  localparam logic [1:0] ANS_DONE    = 2'd1;
  localparam logic [1:0] ANS_TIMEOUT = 2'd2;

  localparam logic [1:0] REG_TRIG_MODE = 2'd0;
  localparam logic [1:0] REG_WINDOW    = 2'd1;
  localparam logic [1:0] REG_HEADER    = 2'd2;
  localparam logic [1:0] REG_MAX_AGE   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_ACCEPT, ST_COUNT, ST_EMIT
  } state_t;

  // Control handed to the window cells.
  typedef struct packed {
    logic shift;   // move every byte one cell toward the head, new byte in tail
  } win_ctl_t;

  // Control handed to the sample cells.
  typedef struct packed {
    logic load;    // capture the window contents
    logic rotate;  // hand every sample to the neighbor toward the head
  } smp_ctl_t;

endpackage

// ===== rtl/tfd_win_cell.sv =====
// One cell of the byte window: holds a byte and carries the parity fold.
module tfd_win_cell
  import tfd_pkg::*;
(
  input  logic     clk,
  input  win_ctl_t ctl,
  input  logic [7:0] byte_in,
  input  logic [7:0] par_in,
  output logic [7:0] byte_out,
  output logic [7:0] par_out
);
  logic [7:0] byte_r, byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.shift) byte_nxt = byte_in;
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_out = byte_r;
  assign par_out  = par_in ^ byte_r;
endmodule

// ===== rtl/tfd_smp_cell.sv =====
// One sample cell: holds a channel value and rotates it toward the output.
module tfd_smp_cell
  import tfd_pkg::*;
(
  input  logic     clk,
  input  smp_ctl_t ctl,
  input  logic [15:0] load_in,
  input  logic [15:0] nbr_in,
  output logic [15:0] smp_out
);
  logic [15:0] smp_r, smp_nxt;

  always_comb begin
    smp_nxt = smp_r;
    if (ctl.load) smp_nxt = load_in;
    else if (ctl.rotate) smp_nxt = nbr_in;
  end

  always_ff @(posedge clk) begin
    smp_r <= smp_nxt;
  end

  assign smp_out = smp_r;
endmodule

// ===== rtl/triggered_frame_deframer.sv =====
// Top level of the triggered frame deframer: control, counters and cell rows.
// Usage:
//  in_* stream carries requests: received byte, trigger edge, frame read,
//  counter read. out_* stream carries results; tlast marks the end of a run.
//  cfg_* APB port writes and reads the four setup registers.
// Timing:
//  A byte request shifts into the window row; once the window is full it
//  also passes through ST_CHECK: a check against the ripple parity through
//  the cell row, a header compare and, for a good frame, the sequence and
//  trigger compares. A good frame then goes through ST_ACCEPT.
//  Trigger (in trigger mode) and counter requests show their result in the
//  cycle after acceptance; a frame read first passes through ST_COUNT.
//  A full frame read sends NUM_CHANNELS+1 results, one a cycle while the
//  receiver takes them, by rotating the sample cell row toward its head.
//  The next request is taken once the last result has been taken.
// Reset empties the window (fill count) and clears counters, trigger and
//  frame status; window and sample cells hold no reset value. A stalled
//  receiver holds the output register and the block waits without losing
//  any result.
module triggered_frame_deframer
  import tfd_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int FRAME_BYTES  = FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] rx_byte, [55:8] now_us, [58:56] stat_index, [63:59] zero
  input  logic [63:0] in_tdata,
  // [1:0] req_type
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] seq_num, [20:16] chan_index, [36:21] sample, [56:37] delay_us,
  // [88:57] stat_value, [96:89] tx_byte, [103:97] zero
  output logic [103:0] out_tdata,
  // [2:0] result_kind
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int CW = $clog2(NUM_CHANNELS + 1);
  localparam int FW = $clog2(FRAME_BYTES + 1);

  // configuration
  logic        trig_mode_r;
  logic [19:0] window_us_r, max_age_us_r;
  logic [7:0]  header_byte_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_mode_r   <= 1'b1;
      window_us_r   <= 20'd20000;
      header_byte_r <= 8'd165;
      max_age_us_r  <= 20'd100000;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TRIG_MODE: trig_mode_r   <= cfg_pwdata[0];
        REG_WINDOW:    window_us_r   <= cfg_pwdata[19:0];
        REG_HEADER:    header_byte_r <= cfg_pwdata[7:0];
        REG_MAX_AGE:   max_age_us_r  <= cfg_pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TRIG_MODE: cfg_prdata = {31'd0, trig_mode_r};
      REG_WINDOW:    cfg_prdata = {12'd0, window_us_r};
      REG_HEADER:    cfg_prdata = {24'd0, header_byte_r};
      REG_MAX_AGE:   cfg_prdata = {12'd0, max_age_us_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // request fields
  logic [7:0]  in_byte;
  logic [47:0] in_now;
  logic [2:0]  in_si;
  assign in_byte = in_tdata[7:0];
  assign in_now  = in_tdata[55:8];
  assign in_si   = in_tdata[58:56];

  logic        in_acc, out_acc;
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // window cell row; cell 0 is the head (oldest byte)
  win_ctl_t    wctl;
  logic [7:0]  wbyte [FRAME_BYTES];
  logic [7:0]  wpar  [FRAME_BYTES+1];
  assign wpar[0] = 8'd0;

  for (genvar g = 0; g < FRAME_BYTES; g++) begin : g_win
    logic [7:0] nb;
    if (g == FRAME_BYTES - 1) begin : g_tail
      assign nb = in_byte;
    end else begin : g_mid
      assign nb = wbyte[g+1];
    end
    tfd_win_cell u_cell (
      .clk(clk), .ctl(wctl), .byte_in(nb), .par_in(wpar[g]),
      .byte_out(wbyte[g]), .par_out(wpar[g+1])
    );
  end

  // parity over bytes 1 .. FRAME_BYTES-2
  logic [7:0] xsum;
  assign xsum = wpar[FRAME_BYTES-1] ^ wbyte[0];

  function automatic logic [7:0] wat(input int i, input logic [7:0] b);
    return (i < FRAME_BYTES) ? b : 8'd0;
  endfunction

  // sample cell row; cell 0 is the next sample out
  smp_ctl_t    sctl;
  logic [15:0] sval [NUM_CHANNELS];
  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_smp
    logic [15:0] ld, nb;
    logic [7:0]  lo, hi;
    if (3 + 2*g < FRAME_BYTES) begin : g_lo
      assign lo = wbyte[(3 + 2*g < FRAME_BYTES) ? 3 + 2*g : 0];
    end else begin : g_lo0
      assign lo = 8'd0;
    end
    if (4 + 2*g < FRAME_BYTES) begin : g_hi
      assign hi = wbyte[(4 + 2*g < FRAME_BYTES) ? 4 + 2*g : 0];
    end else begin : g_hi0
      assign hi = 8'd0;
    end
    assign ld = {hi, lo};
    if (g == NUM_CHANNELS - 1) begin : g_end
      assign nb = sval[0];
    end else begin : g_nx
      assign nb = sval[g+1];
    end
    tfd_smp_cell u_cell (
      .clk(clk), .ctl(sctl), .load_in(ld), .nbr_in(nb), .smp_out(sval[g])
    );
  end

  // status
  state_t      state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt, skip_r, skip_nxt;
  logic [15:0] frame_seq_r, frame_seq_nxt, prev_seq_r, prev_seq_nxt;
  logic [47:0] frame_time_r, frame_time_nxt, trig_time_r, trig_time_nxt;
  logic [47:0] now_r, now_nxt;
  logic        frame_valid_r, frame_valid_nxt, trig_seen_r, trig_seen_nxt;
  logic        prev_known_r, prev_known_nxt;
  logic [1:0]  ans_r, ans_nxt;
  logic [31:0] cnt_r [8];
  logic [7:0]  bump;
  logic        maxlat_wr;
  logic [31:0] maxlat_val;
  logic [CW-1:0] chan_r, chan_nxt;
  logic        take_r, take_nxt;
  logic [47:0] dlt_r, dlt_nxt;

  // output register
  logic        ov_r, ov_nxt, olast_r, olast_nxt;
  logic [2:0]  okind_r, okind_nxt;
  logic [15:0] oseq_r, oseq_nxt, osmp_r, osmp_nxt;
  logic [4:0]  ochan_r, ochan_nxt;
  logic [19:0] olat_r, olat_nxt;
  logic [31:0] ostat_r, ostat_nxt;

  logic [15:0] win_seq;
  logic [47:0] tdiff, age;
  assign win_seq = {wat(2, wbyte[2]), wat(1, wbyte[1])};
  assign tdiff   = now_r - trig_time_r;
  assign age     = (now_r >= frame_time_r) ? now_r - frame_time_r : 48'd0;

  assign in_tready = (state_r == ST_IDLE) && !ov_r;

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r; skip_nxt = skip_r;
    frame_seq_nxt = frame_seq_r; prev_seq_nxt = prev_seq_r;
    frame_time_nxt = frame_time_r; trig_time_nxt = trig_time_r;
    now_nxt = now_r; frame_valid_nxt = frame_valid_r;
    trig_seen_nxt = trig_seen_r; prev_known_nxt = prev_known_r;
    ans_nxt = ans_r; chan_nxt = chan_r;
    take_nxt = take_r; dlt_nxt = dlt_r;
    bump = 8'd0; maxlat_wr = 1'b0; maxlat_val = 32'd0;
    wctl = '0; sctl = '0;
    ov_nxt = ov_r; olast_nxt = olast_r; okind_nxt = okind_r;
    oseq_nxt = oseq_r; osmp_nxt = osmp_r; ochan_nxt = ochan_r;
    olat_nxt = olat_r; ostat_nxt = ostat_r;
    if (out_acc) ov_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          now_nxt = in_now;
          okind_nxt = K_NONE; oseq_nxt = '0; osmp_nxt = '0; ochan_nxt = '0;
          olat_nxt = '0; ostat_nxt = '0; olast_nxt = 1'b1;
          case (in_tuser)
            REQ_BYTE: begin
              wctl.shift = 1'b1;
              if (fill_r != FW'(FRAME_BYTES)) fill_nxt = fill_r + 1'b1;
              if (fill_r >= FW'(FRAME_BYTES - 1)) state_nxt = ST_CHECK;
            end
            REQ_TRIG: begin
              if (trig_mode_r) begin
                if (trig_seen_r && ans_r == ANS_WAIT) bump[C_MISS] = 1'b1;
                trig_time_nxt = in_now; trig_seen_nxt = 1'b1;
                ans_nxt = ANS_WAIT; bump[C_SENT] = 1'b1;
                okind_nxt = K_TRIG; ov_nxt = 1'b1;
              end
            end
            REQ_READ: state_nxt = ST_COUNT;
            default: begin
              okind_nxt = K_STAT; ostat_nxt = cnt_r[in_si]; ov_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_CHECK: begin
        state_nxt = ST_IDLE;
        if (skip_r != '0) skip_nxt = skip_r - 1'b1;
        else if (wbyte[0] != header_byte_r) bump[C_RESYNC] = 1'b1;
        else if (xsum != wbyte[FRAME_BYTES-1]) bump[C_XOR] = 1'b1;
        else begin
          skip_nxt = FW'(FRAME_BYTES - 1);
          if (prev_known_r && (prev_seq_r + 16'd1) != win_seq) bump[C_GAP] = 1'b1;
          prev_seq_nxt = win_seq; prev_known_nxt = 1'b1;
          take_nxt = !trig_mode_r || (trig_seen_r && ans_r == ANS_WAIT &&
                     now_r >= trig_time_r && tdiff <= {28'd0, window_us_r});
          dlt_nxt = tdiff;
          state_nxt = ST_ACCEPT;
        end
      end
      ST_ACCEPT: begin
        state_nxt = ST_IDLE;
        if (!take_r) bump[C_LATE] = 1'b1;
        else begin
          frame_seq_nxt = prev_seq_r; sctl.load = 1'b1;
          frame_time_nxt = now_r; frame_valid_nxt = 1'b1;
          bump[C_OK] = 1'b1;
          if (trig_mode_r) begin
            ans_nxt = ANS_DONE;
            maxlat_wr = 1'b1; maxlat_val = dlt_r[31:0];
          end
        end
      end
      ST_COUNT: begin
        state_nxt = ST_IDLE; ov_nxt = 1'b1; olast_nxt = 1'b1;
        if (trig_mode_r) begin
          if (!trig_seen_r) okind_nxt = K_NONE;
          else if (ans_r == ANS_DONE) begin
            okind_nxt = K_HEAD; olast_nxt = 1'b0; oseq_nxt = frame_seq_r;
            olat_nxt = 20'(frame_time_r - trig_time_r);
            chan_nxt = '0; state_nxt = ST_EMIT;
          end else if (ans_r == ANS_WAIT) begin
            if (now_r >= trig_time_r && tdiff > {28'd0, window_us_r}) begin
              ans_nxt = ANS_TIMEOUT; bump[C_MISS] = 1'b1; okind_nxt = K_TOUT;
            end else okind_nxt = K_PEND;
          end else okind_nxt = K_NONE;
        end else if (!frame_valid_r || age > {28'd0, max_age_us_r}) begin
          okind_nxt = K_NONE;
        end else begin
          okind_nxt = K_HEAD; olast_nxt = 1'b0; oseq_nxt = frame_seq_r;
          olat_nxt = age[19:0]; chan_nxt = '0; state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ov_r || out_acc) begin
          // head cell goes out, row rotates so the order is restored after a lap
          ov_nxt = 1'b1; okind_nxt = K_CHAN; olat_nxt = '0;
          ochan_nxt = 5'(chan_r); osmp_nxt = sval[0]; sctl.rotate = 1'b1;
          olast_nxt = (chan_r == CW'(NUM_CHANNELS - 1));
          chan_nxt = chan_r + 1'b1;
          if (chan_r == CW'(NUM_CHANNELS - 1)) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; fill_r <= '0; skip_r <= '0;
      frame_seq_r <= '0; prev_seq_r <= '0; frame_time_r <= '0;
      trig_time_r <= '0; frame_valid_r <= 1'b0; trig_seen_r <= 1'b0;
      prev_known_r <= 1'b0; ans_r <= ANS_WAIT; ov_r <= 1'b0;
      for (int i = 0; i < 8; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt; fill_r <= fill_nxt; skip_r <= skip_nxt;
      frame_seq_r <= frame_seq_nxt; prev_seq_r <= prev_seq_nxt;
      frame_time_r <= frame_time_nxt; trig_time_r <= trig_time_nxt;
      frame_valid_r <= frame_valid_nxt; trig_seen_r <= trig_seen_nxt;
      prev_known_r <= prev_known_nxt; ans_r <= ans_nxt; ov_r <= ov_nxt;
      for (int i = 0; i < 7; i++)
        if (bump[i] && cnt_r[i] != 32'hFFFF_FFFF) cnt_r[i] <= cnt_r[i] + 32'd1;
      if (maxlat_wr && maxlat_val > cnt_r[C_MAXLAT]) cnt_r[C_MAXLAT] <= maxlat_val;
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt; chan_r <= chan_nxt; take_r <= take_nxt; dlt_r <= dlt_nxt;
    olast_r <= olast_nxt; okind_r <= okind_nxt; oseq_r <= oseq_nxt;
    osmp_r <= osmp_nxt; ochan_r <= ochan_nxt; olat_r <= olat_nxt;
    ostat_r <= ostat_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {7'd0, 8'd0, ostat_r, olat_r, osmp_r, ochan_r, oseq_r};

  `include "triggered_frame_deframer_assert.svh"

  `TFD_ASSERT_IMPL(a_busy_not_ready, state_r != ST_IDLE, !in_tready)
  `TFD_ASSERT_IMPL(a_skip_range, 1'b1, skip_r <= FW'(FRAME_BYTES - 1))
  `TFD_ASSERT_NEXT(a_emit_stays, state_r == ST_EMIT && ov_r && !out_tready,
                   $stable(out_tdata))
endmodule

// ===== test/tb.sv =====
// Self-checking testbench for triggered_frame_deframer: random stream traffic checked against a predictor.
module tb;
  import tfd_pkg::*;

  localparam int NCH = NUM_CHANNELS_DEF;
  localparam int FB = FRAME_BYTES_DEF;
  localparam int LIMIT = 200000;

  typedef struct {
    logic [1:0]  req;
    logic [7:0]  rx;
    logic [47:0] now;
    logic [2:0]  si;
  } request_t;

  typedef struct {
    logic [2:0]  kind;
    logic [15:0] seq;
    logic [4:0]  chan;
    logic [15:0] smp;
    logic [19:0] lat;
    logic [31:0] stat;
    logic        last;
  } result_t;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [63:0]  in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid, out_tready, out_tlast;
  logic [103:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata, cfg_prdata;

  triggered_frame_deframer u_dut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // predictor state
  logic        m_trig;
  logic [19:0] m_window, m_max_age;
  logic [7:0]  m_header;
  logic [7:0]  win_bytes [FB];
  int          win_fill, skip_left;
  logic [15:0] smp_store [NCH];
  logic [15:0] f_seq, last_seq;
  logic [47:0] f_time, trig_time;
  logic        f_valid, trig_seen, last_seq_known;
  logic [1:0]  ans;
  logic [31:0] counters [8];

  request_t pending [$];
  result_t  expected_results [$];
  request_t cur;
  int       gap_left, stall_left, errors, cycles;
  logic     calm;
  logic [47:0] tnow;
  logic [15:0] seq_ctr;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("tb: mismatch %s got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic bump(logic [2:0] idx);
    if (counters[idx] != 32'hFFFF_FFFF) counters[idx]++;
  endtask

  task automatic add_result(logic [2:0] kind, logic [15:0] seq, logic [4:0] chan,
                            logic [15:0] smp, logic [19:0] lat, logic [31:0] stat,
                            logic last);
    result_t r;
    r.kind = kind; r.seq = seq; r.chan = chan; r.smp = smp;
    r.lat = lat; r.stat = stat; r.last = last;
    expected_results.push_back(r);
  endtask

  task automatic frame_results(logic [47:0] lat);
    add_result(K_HEAD, f_seq, 0, 0, lat[19:0], 0, 1'b0);
    for (int i = 0; i < NCH; i++)
      add_result(K_CHAN, f_seq, i[4:0], smp_store[i], 0, 0, i == NCH - 1);
  endtask

  task automatic store_frame(logic [47:0] now);
    logic [15:0] seq;
    logic        take;
    logic [47:0] d;
    seq = {win_bytes[2], win_bytes[1]};
    if (last_seq_known && last_seq + 16'd1 != seq) bump(C_GAP);
    last_seq = seq;
    last_seq_known = 1'b1;
    d = now - trig_time;
    take = m_trig ? (trig_seen && ans == ANS_WAIT && now >= trig_time && d <= m_window)
                  : 1'b1;
    if (!take) begin
      bump(C_LATE);
      return;
    end
    f_seq = seq;
    for (int i = 0; i < NCH; i++) begin
      // channel bytes past the window read as zero
      smp_store[i][7:0]  = (3 + 2 * i < FB) ? win_bytes[3 + 2 * i] : 8'h00;
      smp_store[i][15:8] = (4 + 2 * i < FB) ? win_bytes[4 + 2 * i] : 8'h00;
    end
    f_time = now;
    f_valid = 1'b1;
    bump(C_OK);
    if (m_trig) begin
      ans = ANS_DONE;
      if ({16'd0, d[31:0]} > {16'd0, counters[C_MAXLAT]}) counters[C_MAXLAT] = d[31:0];
    end
  endtask

  task automatic take_byte(logic [7:0] b, logic [47:0] now);
    logic [7:0] x;
    for (int i = 0; i < FB - 1; i++) win_bytes[i] = win_bytes[i + 1];
    win_bytes[FB - 1] = b;
    if (win_fill < FB) win_fill++;
    if (win_fill < FB) return;
    if (skip_left > 0) begin
      skip_left--;
      return;
    end
    if (win_bytes[0] != m_header) begin
      bump(C_RESYNC);
      return;
    end
    x = 0;
    for (int i = 1; i < FB - 1; i++) x ^= win_bytes[i];
    if (x != win_bytes[FB - 1]) begin
      bump(C_XOR);
      return;
    end
    store_frame(now);
    skip_left = FB - 1;
  endtask

  task automatic predict(request_t r);
    logic [47:0] age;
    case (r.req)
      REQ_BYTE: take_byte(r.rx, r.now);
      REQ_TRIG: begin
        if (m_trig) begin
          if (trig_seen && ans == ANS_WAIT) bump(C_MISS);
          trig_time = r.now;
          trig_seen = 1'b1;
          ans = ANS_WAIT;
          bump(C_SENT);
          add_result(K_TRIG, 0, 0, 0, 0, 0, 1'b1);
        end
      end
      REQ_READ: begin
        if (m_trig) begin
          if (!trig_seen) add_result(K_NONE, 0, 0, 0, 0, 0, 1'b1);
          else if (ans == ANS_DONE) frame_results(f_time - trig_time);
          else if (ans == ANS_WAIT) begin
            if (r.now >= trig_time && r.now - trig_time > m_window) begin
              ans = ANS_TIMEOUT;
              bump(C_MISS);
              add_result(K_TOUT, 0, 0, 0, 0, 0, 1'b1);
            end else begin
              add_result(K_PEND, 0, 0, 0, 0, 0, 1'b1);
            end
          end else add_result(K_NONE, 0, 0, 0, 0, 0, 1'b1);
        end else begin
          age = (r.now >= f_time) ? r.now - f_time : 48'd0;
          if (!f_valid || age > m_max_age) add_result(K_NONE, 0, 0, 0, 0, 0, 1'b1);
          else frame_results(age);
        end
      end
      default: add_result(K_STAT, 0, 0, 0, 0, counters[r.si], 1'b1);
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict(cur);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {5'd0, cur.si, cur.now, cur.rx};
          in_tuser <= cur.req;
          gap_left = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result kind", out_tuser, 0);
        end else begin
          e = expected_results.pop_front();
          if (out_tuser != e.kind) report("kind", out_tuser, e.kind);
          if (out_tdata[15:0] != e.seq) report("seq_num", out_tdata[15:0], e.seq);
          if (out_tdata[20:16] != e.chan) report("chan_index", out_tdata[20:16], e.chan);
          if (out_tdata[36:21] != e.smp) report("sample", out_tdata[36:21], e.smp);
          if (out_tdata[56:37] != e.lat) report("delay_us", out_tdata[56:37], e.lat);
          if (out_tdata[88:57] != e.stat) report("stat_value", out_tdata[88:57], e.stat);
          if (out_tdata[96:89] != 8'h00) report("tx_byte", out_tdata[96:89], 0);
          if (out_tlast != e.last) report("last", out_tlast, e.last);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push(logic [1:0] req, logic [7:0] rx, logic [47:0] now, logic [2:0] si);
    request_t r;
    r.req = req; r.rx = rx; r.now = now; r.si = si;
    pending.push_back(r);
  endtask

  // corrupt: 0 clean, 1 bad parity, 2 bad header
  task automatic push_frame(int corrupt, int max_step);
    logic [7:0] fr [FB];
    seq_ctr += ($urandom_range(0, 9) == 0) ? 16'($urandom_range(2, 60000)) : 16'd1;
    fr[0] = m_header;
    fr[1] = seq_ctr[7:0];
    fr[2] = seq_ctr[15:8];
    for (int i = 3; i < FB - 1; i++) fr[i] = 8'($urandom);
    fr[FB - 1] = 0;
    for (int i = 1; i < FB - 1; i++) fr[FB - 1] ^= fr[i];
    if (corrupt == 1) fr[FB - 1] ^= 8'(1 << $urandom_range(0, 7));
    if (corrupt == 2) fr[0] ^= 8'(1 << $urandom_range(0, 7));
    for (int i = 0; i < FB; i++) begin
      tnow += $urandom_range(0, max_step);
      push(REQ_BYTE, fr[i], tnow, 3'($urandom));
    end
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    // a byte that ends in a silent check may still be in flight
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
    case (idx)
      REG_TRIG_MODE: m_trig = val[0];
      REG_WINDOW:    m_window = val[19:0];
      REG_HEADER:    m_header = val[7:0];
      default:       m_max_age = val[19:0];
    endcase
  endtask

  task automatic set_all(logic md, logic [19:0] w, logic [7:0] h, logic [19:0] a);
    wait_idle();
    cfg_write(REG_TRIG_MODE, {31'd0, md});
    cfg_write(REG_WINDOW, {12'd0, w});
    cfg_write(REG_HEADER, {24'd0, h});
    cfg_write(REG_MAX_AGE, {12'd0, a});
    calm = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tdata = '0; in_tuser = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    gap_left = 0; stall_left = 0; errors = 0; cycles = 0; calm = 1'b0;
    m_trig = 1'b1; m_window = 20'd20000; m_header = 8'd165; m_max_age = 20'd100000;
    for (int i = 0; i < FB; i++) win_bytes[i] = 0;
    for (int i = 0; i < 8; i++) counters[i] = 0;
    win_fill = 0; skip_left = 0; f_seq = 0; f_time = 0; f_valid = 0;
    trig_time = 0; trig_seen = 0; ans = ANS_WAIT; last_seq = 0; last_seq_known = 0;
    tnow = 48'd400; seq_ctr = 16'd7;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: trigger mode
    push(REQ_STAT, 8'hFF, tnow, C_OK);
    push(REQ_READ, 8'h00, tnow, 3'd7);          // no trigger yet
    tnow = 48'd1000;
    push(REQ_TRIG, 8'h00, tnow, 3'd0);
    push(REQ_READ, 8'h00, 48'd500, 3'd0);       // read before trigger time: pending
    push_frame(0, 10);
    push(REQ_READ, 8'h00, tnow, 3'd0);
    push(REQ_READ, 8'h00, tnow + 48'd5, 3'd0);
    tnow = 48'd100000;
    push(REQ_TRIG, 8'h00, tnow, 3'd0);
    push(REQ_READ, 8'h00, tnow + 48'd20001, 3'd0); // timeout
    push(REQ_READ, 8'h00, tnow + 48'd20002, 3'd0);
    push(REQ_TRIG, 8'h00, tnow, 3'd0);
    push(REQ_TRIG, 8'h00, tnow + 48'd60000, 3'd0); // earlier one missing
    push(REQ_STAT, 8'h00, tnow, C_MISS);

    // free mode: triggers ignored, stored frame reported by its age
    set_all(1'b0, 20'd1000000, 8'hFF, 20'd50000);
    tnow = 48'd40000;
    push(REQ_TRIG, 8'h00, tnow, 3'd0);
    push(REQ_READ, 8'h00, 48'd0, 3'd0);          // before the frame: age zero
    push(REQ_READ, 8'h00, tnow, 3'd0);
    push(REQ_READ, 8'h00, 48'hFFFF_FFFF_FFFF, 3'd0); // too old
    push_frame(1, 20);                           // bad parity
    push(REQ_STAT, 8'h00, tnow, C_XOR);

    // zero window: a frame one microsecond after its trigger is late
    set_all(1'b1, 20'd0, 8'h5A, 20'd0);
    tnow = 48'hFFFF_FFFF_FF00;
    push(REQ_TRIG, 8'h00, tnow, 3'd0);
    tnow = tnow + 48'd1;
    push_frame(0, 0);
    push(REQ_READ, 8'h00, tnow, 3'd0);           // timeout
    for (int i = 0; i < 8; i++) push(REQ_STAT, 8'h00, tnow, i[2:0]);

    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
